@@ hw/rtl/mcw_pkg.sv @@
// shared types and constants for the minimum covering window block
// no dependencies; imported by every module of the block
package mcw_pkg;

  localparam int MAX_LEN  = 1024;
  localparam int ALPHABET = 128;

  localparam int SYM_W  = $clog2(ALPHABET);
  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int POS_W  = $clog2(MAX_LEN + 1);
  localparam int CNT_W  = $clog2(MAX_LEN + 2);
  localparam int KIND_W = $clog2(ALPHABET + 1);

  // a need count of this value can never be met
  localparam logic [CNT_W-1:0] NEED_CAP  = CNT_W'(MAX_LEN + 1);
  localparam logic [POS_W-1:0] BEST_NONE = '1;

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_SOURCE  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [6:0] char_code;
    logic       last;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  start_index;
    logic [10:0] window_length;
    logic        overflow;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] have;
  } cnt_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [SYM_W-1:0] rd_addr;
    logic             wr_en;
    logic [SYM_W-1:0] wr_addr;
    cnt_entry_t       wr_data;
    logic             clear;
  } cnt_req_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [SYM_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } src_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT,
    ST_SRC,
    ST_CHECK,
    ST_LREAD,
    ST_LUPD,
    ST_DONE
  } state_t;

endpackage

@@ hw/rtl/mcw_count_store.sv @@
// per-character need/have count memory with registered read
// per-entry valid bits let one clear request empty every entry; depends on mcw_pkg
module mcw_count_store import mcw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cnt_req_t   req,
  output cnt_entry_t rd_data
);

  cnt_entry_t            mem [ALPHABET];
  logic [ALPHABET-1:0]   vld_r;
  cnt_entry_t            rd_data_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.clear) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  // entries not written this job read as zero counts
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

@@ hw/rtl/mcw_src_buf.sv @@
// source character buffer, one write and one registered read per cycle
// depends on mcw_pkg
module mcw_src_buf import mcw_pkg::*; (
  input  logic             clk,
  input  src_req_t         req,
  output logic [SYM_W-1:0] rd_data
);

  logic [SYM_W-1:0] mem [MAX_LEN];
  logic [SYM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/min_covering_window.sv @@
// top level of the minimum covering window block: sequencer and result register
// depends on mcw_pkg, mcw_count_store, mcw_src_buf
//
// usage: requests enter on in_valid/in_ready carrying in_data. pattern requests
// (req_type 0) add one to the need count of their character, up to NEED_CAP.
// source requests (req_type 1) are stored and extend the window on the right, or
// are dropped with overflow set when the buffer is full; the window then shrinks
// from the left while it covers the pattern. a source request with last set
// produces one result on out_valid/out_ready and clears the job. timing: a pattern
// request passes ST_PAT, a source request ST_SRC and ST_CHECK, each left shrink
// ST_LREAD, ST_LUPD and ST_CHECK, and a last source request ST_DONE, which loads
// the result. every step is a read-modify-write of the count memory (one read
// port, registered read), which sets the rate; shrinks are bounded by the number
// of source characters. in_ready is high only while the sequencer is idle. the result
// sits in an output register: new requests are taken while it waits, and only the
// next last request stalls in its final cycle until out_ready frees the register.
// reset (rst_n low, synchronous) empties the job and the result register;
// no clearing pass is needed since count entries carry valid bits.
module min_covering_window import mcw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  state_t             state_r, state_nxt;
  in_t                item_r, item_nxt;
  logic [POS_W-1:0]   left_r, left_nxt;
  logic [POS_W-1:0]   right_r, right_nxt;
  logic [KIND_W-1:0]  sat_r, sat_nxt;
  logic [KIND_W-1:0]  req_r, req_nxt;
  logic [POS_W-1:0]   best_len_r, best_len_nxt;
  logic [ADDR_W-1:0]  best_start_r, best_start_nxt;
  logic               ovf_r, ovf_nxt;
  logic [SYM_W-1:0]   lchar_r, lchar_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  cnt_req_t           cnt_req;
  cnt_entry_t         cnt_rd;
  src_req_t           src_req;
  logic [SYM_W-1:0]   src_rd;

  logic [SYM_W-1:0]   in_sym;
  logic [SYM_W-1:0]   item_sym;
  logic [CNT_W-1:0]   need_inc;
  logic [CNT_W-1:0]   have_inc;
  logic [POS_W-1:0]   win_len;
  logic               was_ok;
  logic               now_ok;

  mcw_count_store u_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (cnt_req),
    .rd_data (cnt_rd)
  );

  mcw_src_buf u_src (
    .clk     (clk),
    .req     (src_req),
    .rd_data (src_rd)
  );

  // character codes are reduced modulo the alphabet size
  assign in_sym   = in_data.char_code[SYM_W-1:0];
  assign item_sym = item_r.char_code[SYM_W-1:0];
  assign need_inc = cnt_rd.need + CNT_W'(1);
  assign have_inc = cnt_rd.have + CNT_W'(1);
  assign win_len  = right_r - left_r;
  assign was_ok   = (cnt_rd.need != '0) && (cnt_rd.have >= cnt_rd.need);
  assign now_ok   = (cnt_rd.have >= need_inc);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    sat_nxt        = sat_r;
    req_nxt        = req_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    ovf_nxt        = ovf_r;
    lchar_nxt      = lchar_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    cnt_req        = '0;
    src_req        = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.req_type == REQ_PATTERN) begin
            cnt_req.rd_en   = 1'b1;
            cnt_req.rd_addr = in_sym;
            state_nxt       = ST_PAT;
          end else if (right_r >= POS_W'(MAX_LEN)) begin
            // buffer full: drop the character
            ovf_nxt = 1'b1;
            if (in_data.last) begin
              state_nxt = ST_DONE;
            end
          end else begin
            src_req.wr_en   = 1'b1;
            src_req.wr_addr = right_r[ADDR_W-1:0];
            src_req.wr_data = in_sym;
            cnt_req.rd_en   = 1'b1;
            cnt_req.rd_addr = in_sym;
            state_nxt       = ST_SRC;
          end
        end
      end

      ST_PAT: begin
        if (cnt_rd.need < NEED_CAP) begin
          cnt_req.wr_en        = 1'b1;
          cnt_req.wr_addr      = item_sym;
          cnt_req.wr_data.need = need_inc;
          cnt_req.wr_data.have = cnt_rd.have;
          if (cnt_rd.need == '0) begin
            req_nxt = req_r + KIND_W'(1);
          end
          if (was_ok && !now_ok) begin
            sat_nxt = sat_r - KIND_W'(1);
          end else if (!was_ok && now_ok) begin
            sat_nxt = sat_r + KIND_W'(1);
          end
        end
        state_nxt = ST_IDLE;
      end

      ST_SRC: begin
        cnt_req.wr_en        = 1'b1;
        cnt_req.wr_addr      = item_sym;
        cnt_req.wr_data.need = cnt_rd.need;
        cnt_req.wr_data.have = have_inc;
        right_nxt            = right_r + POS_W'(1);
        if ((cnt_rd.need != '0) && (have_inc == cnt_rd.need)) begin
          sat_nxt = sat_r + KIND_W'(1);
        end
        state_nxt = ST_CHECK;
      end

      ST_CHECK: begin
        if ((req_r != '0) && (sat_r == req_r) && (left_r < right_r)) begin
          if (win_len < best_len_r) begin
            best_len_nxt   = win_len;
            best_start_nxt = left_r[ADDR_W-1:0];
          end
          src_req.rd_en   = 1'b1;
          src_req.rd_addr = left_r[ADDR_W-1:0];
          state_nxt       = ST_LREAD;
        end else if (item_r.last) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_LREAD: begin
        lchar_nxt       = src_rd;
        cnt_req.rd_en   = 1'b1;
        cnt_req.rd_addr = src_rd;
        state_nxt       = ST_LUPD;
      end

      ST_LUPD: begin
        if ((cnt_rd.need != '0) && (cnt_rd.have == cnt_rd.need)) begin
          sat_nxt = sat_r - KIND_W'(1);
        end
        cnt_req.wr_en        = 1'b1;
        cnt_req.wr_addr      = lchar_r;
        cnt_req.wr_data.need = cnt_rd.need;
        cnt_req.wr_data.have = (cnt_rd.have != '0) ? cnt_rd.have - CNT_W'(1) : cnt_rd.have;
        left_nxt             = left_r + POS_W'(1);
        state_nxt            = ST_CHECK;
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (req_r == '0) begin
            out_data_nxt.found         = 1'b1;
            out_data_nxt.start_index   = '0;
            out_data_nxt.window_length = '0;
          end else if (best_len_r != BEST_NONE) begin
            out_data_nxt.found         = 1'b1;
            out_data_nxt.start_index   = 10'(best_start_r);
            out_data_nxt.window_length = 11'(best_len_r);
          end else begin
            out_data_nxt.found         = 1'b0;
            out_data_nxt.start_index   = '0;
            out_data_nxt.window_length = '0;
          end
          out_data_nxt.overflow = ovf_r;
          // start a fresh job
          cnt_req.clear  = 1'b1;
          left_nxt       = '0;
          right_nxt      = '0;
          sat_nxt        = '0;
          req_nxt        = '0;
          best_len_nxt   = BEST_NONE;
          best_start_nxt = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      left_r       <= '0;
      right_r      <= '0;
      sat_r        <= '0;
      req_r        <= '0;
      best_len_r   <= BEST_NONE;
      best_start_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      sat_r        <= sat_nxt;
      req_r        <= req_nxt;
      best_len_r   <= best_len_nxt;
      best_start_r <= best_start_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    lchar_r    <= lchar_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ hw/rtl/mcw_checker.sv @@
// port-level checks for min_covering_window, bound to the top level
// depends on mcw_pkg and min_covering_window
module mcw_checker import mcw_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a miss reports a zero window
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      (out_data.start_index == '0) && (out_data.window_length == '0))
    else $error("miss with nonzero window");

  // a found window lies inside the buffer
  a_window_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |->
      (12'(out_data.start_index) + 12'(out_data.window_length)) <= 12'(MAX_LEN))
    else $error("window runs past the buffer");

  // a zero-length window only comes at start zero
  a_empty_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.window_length == '0) |-> (out_data.start_index == '0))
    else $error("empty window with nonzero start");

endmodule

bind min_covering_window mcw_checker u_mcw_checker (.*);

@@ tb/sv/mcw_window_check.sv @@
`timescale 1ns / 100ps
// result checker for min_covering_window: follows both channels, predicts each
// window result from the accepted requests and compares it; depends on mcw_pkg
module mcw_window_check import mcw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   outstanding
);

  localparam int unsigned NEED_LIMIT = MAX_LEN + 1;
  localparam int unsigned NO_WINDOW  = 32'hFFFF_FFFF;

  int unsigned      need_cnt[ALPHABET];
  int unsigned      have_cnt[ALPHABET];
  logic [SYM_W-1:0] text_mem[MAX_LEN];
  int unsigned      win_left, win_right;
  int unsigned      kinds_met, kinds_needed;
  int unsigned      best_len, best_pos;
  logic             text_overrun;
  out_t             window_q[$];
  int               errors = 0;

  function automatic void close_job();
    foreach (need_cnt[i]) begin
      need_cnt[i] = 0;
      have_cnt[i] = 0;
    end
    win_left     = 0;
    win_right    = 0;
    kinds_met    = 0;
    kinds_needed = 0;
    best_len     = NO_WINDOW;
    best_pos     = 0;
    text_overrun = 1'b0;
  endfunction

  function automatic void count_pattern_char(int unsigned c);
    int unsigned n;
    bit was_met, now_met;
    n = need_cnt[c];
    was_met = n > 0 && have_cnt[c] >= n;
    // a saturated count stays unreachable
    if (n >= NEED_LIMIT) return;
    n++;
    need_cnt[c] = n;
    if (n == 1) kinds_needed++;
    now_met = have_cnt[c] >= n;
    if (was_met && !now_met) kinds_met--;
    else if (!was_met && now_met) kinds_met++;
  endfunction

  function automatic void take_source_char(int unsigned c);
    int unsigned l;
    if (win_right >= MAX_LEN) begin
      text_overrun = 1'b1;
      return;
    end
    text_mem[win_right] = SYM_W'(c);
    win_right++;
    have_cnt[c]++;
    if (need_cnt[c] > 0 && have_cnt[c] == need_cnt[c]) kinds_met++;
    // shrink from the left while the window still covers the pattern
    while (kinds_needed > 0 && kinds_met == kinds_needed && win_left < win_right) begin
      if (win_right - win_left < best_len) begin
        best_len = win_right - win_left;
        best_pos = win_left;
      end
      l = text_mem[win_left] % ALPHABET;
      if (need_cnt[l] > 0 && have_cnt[l] == need_cnt[l]) kinds_met--;
      if (have_cnt[l] > 0) have_cnt[l]--;
      win_left++;
    end
  endfunction

  function automatic out_t job_result();
    out_t r;
    r = '0;
    if (kinds_needed == 0) begin
      r.found = 1'b1;
    end else if (best_len != NO_WINDOW) begin
      r.found         = 1'b1;
      r.start_index   = 10'(best_pos);
      r.window_length = 11'(best_len);
    end
    r.overflow = text_overrun;
    return r;
  endfunction

  task automatic report(string msg);
    errors++;
    $display("[chk] %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    out_t want;
    in_t  req;
    if (!rst_n) begin
      close_job();
      window_q.delete();
    end else begin
      // retire first: a result never belongs to a request taken at the same edge
      if (out_valid && out_ready) begin
        if (window_q.size() == 0) begin
          report($sformatf("result with nothing pending: %p", out_data));
        end else begin
          want = window_q.pop_front();
          if (out_data.found !== want.found)
            report($sformatf("found %0b, expected %0b", out_data.found, want.found));
          if (out_data.start_index !== want.start_index)
            report($sformatf("start_index %0d, expected %0d",
                             out_data.start_index, want.start_index));
          if (out_data.window_length !== want.window_length)
            report($sformatf("window_length %0d, expected %0d",
                             out_data.window_length, want.window_length));
          if (out_data.overflow !== want.overflow)
            report($sformatf("overflow %0b, expected %0b", out_data.overflow, want.overflow));
        end
      end
      if (in_valid && in_ready) begin
        req = in_data;
        if (req.req_type == REQ_PATTERN) begin
          count_pattern_char(req.char_code % ALPHABET);
        end else begin
          take_source_char(req.char_code % ALPHABET);
          if (req.last) begin
            window_q.push_back(job_result());
            close_job();
          end
        end
      end
    end
    outstanding <= window_q.size();
    fail_count  <= errors;
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// top of the min_covering_window testbench: clock, reset, request stimulus and verdict
// depends on mcw_pkg, min_covering_window and mcw_window_check
module tb;
  import mcw_pkg::*;

  localparam int RANDOM_ITEMS = 650;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   outstanding;

  logic        calm    = 1'b0;
  logic        hold_go = 1'b0;
  bit          quiet;
  int          sent_cnt = 0;
  int          job_cnt  = 0;
  int unsigned cycle_cnt = 0;
  logic [6:0]  palette[8];
  int          pal_n;

  always #1 clk = ~clk;

  min_covering_window dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  mcw_window_check window_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[min_covering_window] ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off, none once calm
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic kind, logic [6:0] code, logic fin);
    in_t r;
    r.req_type  = kind;
    r.char_code = code;
    r.last      = fin;
    if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
    if (kind == REQ_SOURCE && fin) job_cnt++;
  endtask

  task automatic put_pattern(logic [6:0] code, logic fin = 1'b0);
    send_item(REQ_PATTERN, code, fin);
  endtask

  task automatic put_source(logic [6:0] code, logic fin = 1'b0);
    send_item(REQ_SOURCE, code, fin);
  endtask

  // stop offering until every pending result is out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [6:0] pick_char();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    return palette[$urandom_range(0, pal_n - 1)];
  endfunction

  task automatic random_job();
    int npat, nsrc, noise;
    quiet = ($urandom_range(0, 3) == 0);
    pal_n = $urandom_range(1, 8);
    for (int i = 0; i < pal_n; i++) palette[i] = 7'($urandom_range(0, 127));
    noise = $urandom_range(0, 9);
    npat  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    nsrc  = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
    for (int i = 0; i < npat; i++)
      put_pattern(pick_char(), (noise == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
    for (int i = 0; i < nsrc; i++) begin
      // late pattern requests in the middle of the source
      if (noise == 1 && $urandom_range(0, 7) == 0) put_pattern(pick_char());
      put_source(pick_char(), i == nsrc - 1);
    end
  endtask

  task automatic long_jobs();
    // window spanning the whole buffer, then an overrun past its end
    put_pattern(7'd0);
    put_pattern(7'd127);
    put_source(7'd0);
    for (int i = 0; i < 1022; i++) put_source(7'($urandom_range(1, 126)));
    put_source(7'd127);
    for (int i = 0; i < 6; i++) put_source(7'($urandom_range(0, 127)), i == 5);
  endtask

  initial begin
    int base;
    quiet = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern
    put_source(7'd0, 1'b1);
    // code extremes, last flag on a pattern request
    put_pattern(7'd127);
    put_pattern(7'd0, 1'b1);
    put_source(7'd5);
    put_source(7'd127);
    put_source(7'd9);
    put_source(7'd0);
    put_source(7'd127, 1'b1);
    // count never met
    put_pattern(7'd3);
    put_pattern(7'd3);
    put_source(7'd3);
    put_source(7'd1, 1'b1);
    // pattern arriving after source
    put_pattern(7'd10);
    put_source(7'd10);
    put_source(7'd11);
    put_pattern(7'd11);
    put_source(7'd12);
    put_source(7'd11, 1'b1);
    // repeated characters
    put_pattern(7'd65);
    put_pattern(7'd66);
    put_pattern(7'd65);
    put_source(7'd65);
    put_source(7'd66);
    put_source(7'd67);
    put_source(7'd65, 1'b1);
    drain();

    long_jobs();
    drain();

    base = sent_cnt;
    while (sent_cnt - base < RANDOM_ITEMS) begin
      if (!hold_go && sent_cnt - base > 300) hold_go <= 1'b1;
      if (!calm && sent_cnt - base > RANDOM_ITEMS * 85 / 100) calm <= 1'b1;
      random_job();
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("[tb] %0d requests in %0d jobs: directed corners, full-depth window",
             sent_cnt, job_cnt);
    $display("[tb] with buffer overrun, random jobs with stalls on both sides");
    if (fail_count == 0) begin
      $display("[min_covering_window] OK");
    end else begin
      $display("[min_covering_window] ERROR");
    end
    $finish;
  end

endmodule

@@ min_covering_window.f @@
hw/rtl/mcw_pkg.sv
hw/rtl/mcw_count_store.sv
hw/rtl/mcw_src_buf.sv
hw/rtl/min_covering_window.sv
hw/rtl/mcw_checker.sv
tb/sv/mcw_window_check.sv
tb/sv/tb.sv
